### hdl/mfs_pkg.sv
// Shared types and constants of the multilevel feedback scheduler.
`timescale 1ns / 1ps

package mfs_pkg;

  localparam int unsigned JobW    = 8;
  localparam int unsigned CountW  = 8;
  localparam int unsigned LimitW  = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned NumLvl  = 3;

  localparam logic [LimitW-1:0] HighLimitRst   = 8'd2;
  localparam logic [LimitW-1:0] MediumLimitRst = 8'd4;
  localparam logic [CountW-1:0] CountMax       = 8'd255;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_TICK = 2'd1,
    CMD_DONE = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_REQUEUE = 2'd1,
    ACT_DEMOTE  = 2'd2,
    ACT_FINISH  = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    LVL_HIGH   = 2'd0,
    LVL_MEDIUM = 2'd1,
    LVL_LOW    = 2'd2,
    LVL_NONE   = 2'd3
  } lvl_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HIGH_LIMIT   = 2'd0,
    REG_MEDIUM_LIMIT = 2'd1,
    REG_UNUSED2      = 2'd2,
    REG_UNUSED3      = 2'd3
  } reg_e;

  typedef struct packed {
    logic [JobW-1:0]   job_id;
    logic [CountW-1:0] count;
  } entry_t;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [JobW-1:0] job_id;
  } in_word_t;

  typedef struct packed {
    logic [JobW-1:0] off_job_id;
    logic [1:0]      off_action;
    logic            next_valid;
    logic [JobW-1:0] next_job_id;
    logic [1:0]      next_level;
    logic            overflow;
  } out_word_t;

  typedef struct packed {
    logic   pop;
    logic   push;
    entry_t entry;
  } q_ctrl_t;

  typedef struct packed {
    logic   empty;
    entry_t head;
    logic   next_empty;
    entry_t next_head;
  } q_stat_t;

endpackage

### hdl/multilevel_feedback_scheduler_unit.sv
// Top level of the multilevel feedback scheduler: command decode and result register.
`timescale 1ns / 1ps

// Three-level feedback scheduler. Each accepted command word (add, quantum tick,
// done, no-op) gives exactly one result word, registered, the cycle after acceptance.
// A new command is taken every cycle: in_ready_o drops only while a result is
// held and out_ready_i is low. All updates touch the queue heads and tails of
// three shifting FIFOs of MAX_JOBS slots each, in one pass between the command
// and the result register. No clearing pass follows reset; queue slots are
// guarded by fill counts. Limits are written on the cfg port, which is always ready.
module multilevel_feedback_scheduler_unit
  import mfs_pkg::*;
#(
  parameter int unsigned MAX_JOBS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_word_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_word_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [LimitW-1:0]  cfg_data_i
);

  localparam int unsigned CntW = $clog2(MAX_JOBS + 1);

  logic [LimitW-1:0] high_limit_q, medium_limit_q;
  logic [CntW-1:0]   jobs_q, jobs_d;
  logic              out_valid_q;
  out_word_t         out_q, out_d;
  logic              accept;

  q_ctrl_t q_ctrl [NumLvl];
  q_stat_t q_stat [NumLvl];

  lvl_e        lvl, next_lvl;
  entry_t      head;
  entry_t      next_head;
  logic [CountW-1:0] cnt_inc;
  logic        demote;

  for (genvar l = 0; l < NumLvl; l++) begin : g_lvl
    mfs_queue #(
      .Depth (MAX_JOBS)
    ) u_queue (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (q_ctrl[l]),
      .stat_o (q_stat[l])
    );
  end

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (!q_stat[0].empty) begin
      lvl  = LVL_HIGH;
      head = q_stat[0].head;
    end else if (!q_stat[1].empty) begin
      lvl  = LVL_MEDIUM;
      head = q_stat[1].head;
    end else if (!q_stat[2].empty) begin
      lvl  = LVL_LOW;
      head = q_stat[2].head;
    end else begin
      lvl  = LVL_NONE;
      head = '0;
    end
  end

  assign cnt_inc = (head.count == CountMax) ? CountMax : head.count + 8'd1;

  always_comb begin
    case (lvl)
      LVL_HIGH:   demote = (cnt_inc >= high_limit_q);
      LVL_MEDIUM: demote = (cnt_inc >= medium_limit_q);
      default:    demote = 1'b0;
    endcase
  end

  always_comb begin
    for (int l = 0; l < NumLvl; l++) begin
      q_ctrl[l] = '0;
    end
    jobs_d           = jobs_q;
    out_d            = '0;
    out_d.off_action = ACT_NONE;
    if (accept) begin
      case (cmd_e'(in_data_i.cmd))
        CMD_ADD: begin
          if (jobs_q >= CntW'(MAX_JOBS)) begin
            out_d.overflow = 1'b1;
          end else begin
            q_ctrl[0].push  = 1'b1;
            q_ctrl[0].entry = '{job_id: in_data_i.job_id, count: '0};
            jobs_d          = jobs_q + CntW'(1);
          end
        end
        CMD_TICK: begin
          if (lvl != LVL_NONE) begin
            q_ctrl[lvl].pop  = 1'b1;
            out_d.off_job_id = head.job_id;
            if (demote) begin
              q_ctrl[lvl + 2'd1].push  = 1'b1;
              q_ctrl[lvl + 2'd1].entry = '{job_id: head.job_id, count: cnt_inc};
              out_d.off_action         = ACT_DEMOTE;
            end else begin
              q_ctrl[lvl].push  = 1'b1;
              q_ctrl[lvl].entry = '{job_id: head.job_id, count: cnt_inc};
              out_d.off_action  = ACT_REQUEUE;
            end
          end
        end
        CMD_DONE: begin
          if (lvl != LVL_NONE) begin
            q_ctrl[lvl].pop  = 1'b1;
            out_d.off_job_id = head.job_id;
            out_d.off_action = ACT_FINISH;
            jobs_d           = jobs_q - CntW'(1);
          end
        end
        default: begin
        end
      endcase
    end

    // next job comes from the queue state after this word's update
    if (!q_stat[0].next_empty) begin
      next_lvl  = LVL_HIGH;
      next_head = q_stat[0].next_head;
    end else if (!q_stat[1].next_empty) begin
      next_lvl  = LVL_MEDIUM;
      next_head = q_stat[1].next_head;
    end else if (!q_stat[2].next_empty) begin
      next_lvl  = LVL_LOW;
      next_head = q_stat[2].next_head;
    end else begin
      next_lvl  = LVL_NONE;
      next_head = '0;
    end
    if (next_lvl != LVL_NONE) begin
      out_d.next_valid  = 1'b1;
      out_d.next_job_id = next_head.job_id;
      out_d.next_level  = next_lvl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_limit_q   <= HighLimitRst;
      medium_limit_q <= MediumLimitRst;
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_HIGH_LIMIT:   high_limit_q   <= cfg_data_i;
        REG_MEDIUM_LIMIT: medium_limit_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jobs_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      jobs_q <= jobs_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hdl/mfs_queue.sv
// One level of the scheduler: a shifting FIFO whose head sits in slot zero.
`timescale 1ns / 1ps

module mfs_queue
  import mfs_pkg::*;
#(
  parameter int unsigned Depth = 8
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_ctrl_t ctrl_i,
  output q_stat_t stat_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [CntW-1:0] fill_q, fill_d, base_fill;
  entry_t          slot_q [Depth];
  entry_t          slot_d [Depth];

  always_comb begin
    base_fill = fill_q - CntW'(ctrl_i.pop);
    fill_d    = base_fill + CntW'(ctrl_i.push);
    for (int i = 0; i < Depth; i++) begin
      if (ctrl_i.pop && (i < Depth - 1)) begin
        slot_d[i] = slot_q[(i < Depth - 1) ? i + 1 : i];
      end else begin
        slot_d[i] = slot_q[i];
      end
      // the pushed word lands just behind the last survivor
      if (ctrl_i.push && (base_fill == CntW'(i))) begin
        slot_d[i] = ctrl_i.entry;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  assign stat_o.empty      = (fill_q == '0);
  assign stat_o.head       = slot_q[0];
  assign stat_o.next_empty = (fill_d == '0);
  assign stat_o.next_head  = slot_d[0];

endmodule

### hdl/mfs_checker.sv
// Port-level checks for the multilevel feedback scheduler, bound to the top level.
`timescale 1ns / 1ps

module mfs_checker
  import mfs_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_data_o
);

  // a held result word does not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // every accepted command word shows a result on the next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted word gave no result");

  a_ovf_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow |->
      out_data_o.off_action == ACT_NONE && out_data_o.off_job_id == '0)
    else $error("refused add touched a job");

  a_no_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.next_valid |->
      out_data_o.next_job_id == '0 && out_data_o.next_level == LVL_HIGH)
    else $error("empty scheduler reported a next job");

  a_next_lvl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.next_valid |-> out_data_o.next_level != LVL_NONE)
    else $error("next level out of range");

endmodule

bind multilevel_feedback_scheduler_unit mfs_checker u_mfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
